[hw/rtl/mlpq_pkg.sv]
// Package for the multi-level priority FIFO: shared types, codes and defaults.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mlpq_pkg;

	// Default configuration, handed down from the top level.
	localparam int LEVELS_DEF = 8;
	localparam int DEPTH_DEF  = 16;

	// Widths fixed by the item fields.
	localparam int DATA_W  = 32;
	localparam int PRIO_W  = 3;
	localparam int STAT_W  = 2;

	// Action codes.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// Status codes.
	localparam logic [STAT_W-1:0] OP_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] OP_REJECT    = 2'd1;
	localparam logic [STAT_W-1:0] OP_UNDERFLOW = 2'd2;

	// Value reported when every level is empty.
	localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

	// Command from the sequencer to the level table.
	typedef struct packed {
		logic strobe;
		logic pop;
	} lvl_cmd_t;

	// Decision and status returned by the level table.
	typedef struct packed {
		logic wr_en;
		logic reject;
		logic underflow;
		logic empty;
	} lvl_resp_t;

endpackage

[hw/rtl/mlpq_entry_ram.sv]
// Entry store of the priority FIFO: one synchronous RAM, one write and one read port.
// The read data is registered; uses mlpq_pkg.
`timescale 1ns / 1ps

module mlpq_entry_ram #(
	parameter int WORDS = mlpq_pkg::LEVELS_DEF * mlpq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(WORDS)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [mlpq_pkg::DATA_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [mlpq_pkg::DATA_W-1:0] rdata
);
	import mlpq_pkg::*;

	logic [DATA_W-1:0] mem_q [WORDS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/mlpq_level_table.sv]
// Per-level FIFO bookkeeping: head and tail pointers, fill counts and the
// priority encoder that picks the most urgent non-empty level; uses mlpq_pkg.
`timescale 1ns / 1ps

module mlpq_level_table #(
	parameter int LEVELS = mlpq_pkg::LEVELS_DEF,
	parameter int DEPTH  = mlpq_pkg::DEPTH_DEF,
	parameter int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1,
	parameter int PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mlpq_pkg::lvl_cmd_t          cmd,
	input  logic [mlpq_pkg::PRIO_W-1:0] priority_level,
	output mlpq_pkg::lvl_resp_t         resp,
	output logic [LW-1:0]               push_lvl,
	output logic [PW-1:0]               wr_ptr,
	output logic [LW-1:0]               top_lvl,
	output logic [PW-1:0]               top_head
);
	import mlpq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = LW + PRIO_W;

	logic [PW-1:0] head_q  [LEVELS];
	logic [PW-1:0] tail_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];

	logic [XW-1:0] lvl_x;
	logic          lvl_ok;
	logic          any_busy;
	logic [LW-1:0] op_lvl;
	logic [CW-1:0] cnt_sel;
	logic          full;
	logic          is_push;
	logic          is_pop;
	logic          do_pop;

	// Requested level, checked against the number of levels.
	always_comb begin
		lvl_x    = XW'(priority_level);
		lvl_ok   = 32'(lvl_x) < LEVELS;
		push_lvl = lvl_x[LW-1:0];
	end

	// Priority encoder: lowest-numbered level that holds a value.
	always_comb begin
		any_busy = 1'b0;
		top_lvl  = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				any_busy = 1'b1;
				top_lvl  = LW'(i);
			end
		end
	end

	// Decision for the current command.
	always_comb begin
		is_push   = cmd.strobe && (cmd.pop == ACT_PUSH);
		is_pop    = cmd.strobe && (cmd.pop == ACT_POP);
		op_lvl    = is_pop ? top_lvl : push_lvl;
		cnt_sel   = count_q[op_lvl];
		full      = cnt_sel == CW'(DEPTH);
		do_pop    = is_pop && any_busy;
		resp.wr_en     = is_push && lvl_ok && !full;
		resp.reject    = is_push && !(lvl_ok && !full);
		resp.underflow = is_pop && !any_busy;
		resp.empty     = !any_busy;
		wr_ptr    = tail_q[push_lvl];
		top_head  = head_q[top_lvl];
	end

	// Pointer and count update; pointers wrap from the last slot to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (resp.wr_en) begin
			tail_q[push_lvl]  <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
			count_q[push_lvl] <= cnt_sel + 1'b1;
		end else if (do_pop) begin
			head_q[top_lvl]  <= (top_head == PW'(DEPTH - 1)) ? '0 : top_head + 1'b1;
			count_q[top_lvl] <= cnt_sel - 1'b1;
		end
	end

endmodule

[hw/rtl/multi_level_priority_fifo.sv]
// Multi-level priority FIFO: one circular FIFO per level in a shared entry RAM.
// The done strobe comes in ST_OUT, after the ST_READ state that follows the take of start.
// Start can be taken again while a result is presented, not during the RAM read.
// Reset clears all pointers and counts at once; no clearing pass is needed.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module multi_level_priority_fifo #(
	parameter int LEVELS = mlpq_pkg::LEVELS_DEF,
	parameter int DEPTH  = mlpq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic signed [mlpq_pkg::DATA_W-1:0] item_value,
	input  logic        [mlpq_pkg::PRIO_W-1:0] priority_level,
	output logic                               done,
	output logic signed [mlpq_pkg::DATA_W-1:0] top_value,
	output logic                               queue_empty,
	output logic        [mlpq_pkg::STAT_W-1:0] op_status
);
	import mlpq_pkg::*;

	localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WORDS = LEVELS * DEPTH;
	localparam int AW    = $clog2(WORDS);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]        state_q;
	logic [STAT_W-1:0] status_q;
	logic              empty_q;

	lvl_cmd_t          cmd;
	lvl_resp_t         resp;
	logic [LW-1:0]     push_lvl;
	logic [PW-1:0]     wr_ptr;
	logic [LW-1:0]     top_lvl;
	logic [PW-1:0]     top_head;
	logic              take;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rdata;

	// A transfer is taken whenever start is high outside the read cycle.
	always_comb begin
		busy       = state_q == ST_READ;
		take       = start && !busy;
		cmd.strobe = take;
		cmd.pop    = action;
	end

	mlpq_level_table #(
		.LEVELS (LEVELS),
		.DEPTH  (DEPTH),
		.LW     (LW),
		.PW     (PW)
	) u_table (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.priority_level (priority_level),
		.resp           (resp),
		.push_lvl       (push_lvl),
		.wr_ptr         (wr_ptr),
		.top_lvl        (top_lvl),
		.top_head       (top_head)
	);

	// RAM addresses: level base plus slot within the level.
	always_comb begin
		mem_we = resp.wr_en;
		mem_re = state_q == ST_READ;
		waddr  = AW'(push_lvl) * AW'(DEPTH) + AW'(wr_ptr);
		raddr  = AW'(top_lvl) * AW'(DEPTH) + AW'(top_head);
	end

	mlpq_entry_ram #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (item_value),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer: update on the transfer, read the new head, then present it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: state_q <= take ? ST_READ : ST_IDLE;
				ST_READ: state_q <= ST_OUT;
				ST_OUT:  state_q <= take ? ST_READ : ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Status is settled at the transfer; emptiness after the update, in the read cycle.
	always_ff @(posedge clk) begin
		if (take) begin
			if (resp.reject) begin
				status_q <= OP_REJECT;
			end else if (resp.underflow) begin
				status_q <= OP_UNDERFLOW;
			end else begin
				status_q <= OP_DONE;
			end
		end
		if (state_q == ST_READ) begin
			empty_q <= resp.empty;
		end
	end

	// Result ports.
	always_comb begin
		done        = state_q == ST_OUT;
		queue_empty = empty_q;
		op_status   = status_q;
		top_value   = empty_q ? EMPTY_VALUE : rdata;
	end

	// A transfer always leads to a read cycle.
	a_take_reads: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy)
		else $error("transfer not followed by a read cycle");

	// Every result follows a read cycle.
	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding read cycle");

	// A rejected push never writes the entry RAM.
	a_reject_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(take && resp.reject) |-> !mem_we)
		else $error("rejected push wrote the entry store");

	// Only defined status codes are reported.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (op_status == OP_DONE || op_status == OP_REJECT
			|| op_status == OP_UNDERFLOW))
		else $error("undefined status code on a result");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the multi-level priority FIFO.
// Depends on mlpq_pkg and multi_level_priority_fifo; drives push and pop commands and
// checks every reported head value, empty flag and status against its own queue model.
`timescale 1ns / 1ps

module tb_top;
	import mlpq_pkg::*;

	localparam int LEVELS         = LEVELS_DEF;
	localparam int DEPTH          = DEPTH_DEF;
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_ITEMS   = 750;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	// One command as the driver sees it, with its pacing.
	typedef struct {
		logic                     action;
		logic signed [DATA_W-1:0] value;
		logic        [PRIO_W-1:0] level;
		int                       idle_pct;
		bit                       wait_empty;
	} push_pop_t;

	// One report of the queue after a command.
	typedef struct {
		logic signed [DATA_W-1:0] top_value;
		logic                     queue_empty;
		logic        [STAT_W-1:0] op_status;
	} queue_report_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     start          = 1'b0;
	logic                     action         = ACT_PUSH;
	logic signed [DATA_W-1:0] item_value     = '0;
	logic        [PRIO_W-1:0] priority_level = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] top_value;
	logic                     queue_empty;
	logic        [STAT_W-1:0] op_status;

	push_pop_t     cmd_backlog[$];
	queue_report_t pending_reports[$];
	push_pop_t     cmd_in_flight;
	int            reports_owed = 0;
	int            fail_count   = 0;
	int            quiet_cycles = 0;

	// Shadow copy of the level FIFOs.
	logic signed [DATA_W-1:0] slots [LEVELS][DEPTH];
	int                       rd_ptr [LEVELS];
	int                       wr_ptr [LEVELS];
	int                       fill   [LEVELS];

	multi_level_priority_fifo #(
		.LEVELS(LEVELS),
		.DEPTH (DEPTH)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.item_value    (item_value),
		.priority_level(priority_level),
		.done          (done),
		.top_value     (top_value),
		.queue_empty   (queue_empty),
		.op_status     (op_status)
	);

	always #HALF_PERIOD clk = ~clk;

	// The most urgent level holding a value, or LEVELS when all are empty.
	function automatic int urgent_level();
		for (int lv = 0; lv < LEVELS; lv++) begin
			if (fill[lv] != 0)
				return lv;
		end
		return LEVELS;
	endfunction

	// Applies one command to the shadow FIFOs and returns the report it should produce.
	function automatic queue_report_t queue_apply(push_pop_t cmd);
		queue_report_t rep;
		int            lv;
		rep.op_status = OP_DONE;
		if (cmd.action == ACT_PUSH) begin
			lv = cmd.level;
			if (lv >= LEVELS || fill[lv] >= DEPTH) begin
				rep.op_status = OP_REJECT;
			end else begin
				slots[lv][wr_ptr[lv]] = cmd.value;
				wr_ptr[lv] = (wr_ptr[lv] + 1) % DEPTH;
				fill[lv]++;
			end
		end else begin
			lv = urgent_level();
			if (lv >= LEVELS) begin
				rep.op_status = OP_UNDERFLOW;
			end else begin
				rd_ptr[lv] = (rd_ptr[lv] + 1) % DEPTH;
				fill[lv]--;
			end
		end
		lv = urgent_level();
		rep.queue_empty = (lv >= LEVELS);
		rep.top_value   = rep.queue_empty ? EMPTY_VALUE : slots[lv][rd_ptr[lv]];
		return rep;
	endfunction

	task automatic add_cmd(logic act, logic signed [DATA_W-1:0] val, int lv, int idle,
			bit wait_empty);
		push_pop_t cmd;
		cmd.action     = act;
		cmd.value      = val;
		cmd.level      = lv[PRIO_W-1:0];
		cmd.idle_pct   = idle;
		cmd.wait_empty = wait_empty;
		cmd_backlog.push_back(cmd);
	endtask

	// Mostly plain random words, now and then an extreme.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(11))
			0:       return {1'b0, {(DATA_W-1){1'b1}}};
			1:       return {1'b1, {(DATA_W-1){1'b0}}};
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// Driver: holds a command until it is taken, then predicts its report.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start          <= 1'b0;
			action         <= ACT_PUSH;
			item_value     <= '0;
			priority_level <= '0;
		end else begin
			if (start && !busy) begin
				pending_reports.push_back(queue_apply(cmd_in_flight));
				reports_owed++;
			end
			if (done)
				reports_owed--;
			if (start && busy) begin
				// Transfer still waiting; keep the command on the ports.
			end else if (cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].wait_empty && reports_owed != 0) &&
					$urandom_range(99) >= cmd_backlog[0].idle_pct) begin
				cmd_in_flight  = cmd_backlog.pop_front();
				start          <= 1'b1;
				action         <= cmd_in_flight.action;
				item_value     <= cmd_in_flight.value;
				priority_level <= cmd_in_flight.level;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed report is checked against the oldest prediction.
	always @(posedge clk) begin : report_check
		queue_report_t want;
		if (arst_n && done) begin
			if (pending_reports.size() == 0) begin
				$error("report with no command outstanding: top_value %0d", top_value);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (top_value !== want.top_value) begin
					$error("top_value: expected %0d, got %0d", want.top_value, top_value);
					fail_count++;
				end
				if (queue_empty !== want.queue_empty) begin
					$error("queue_empty: expected %0b, got %0b", want.queue_empty,
						queue_empty);
					fail_count++;
				end
				if (op_status !== want.op_status) begin
					$error("op_status: expected %0d, got %0d", want.op_status, op_status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer or report ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int idle;
		int made;
		int mode;
		int burst_len;
		int hot;
		int push_pct;
		logic act;
		int lv;

		for (int i = 0; i < LEVELS; i++) begin
			rd_ptr[i] = 0;
			wr_ptr[i] = 0;
			fill[i]   = 0;
		end

		// Directed: underflow on an empty queue, extremes of value and level, then
		// one level filled to the brim and a push rejected.
		add_cmd(ACT_POP,  32'h1234_5678, 7, 0, 1'b0);
		add_cmd(ACT_PUSH, {1'b0, {(DATA_W-1){1'b1}}}, 7, 0, 1'b0);
		add_cmd(ACT_PUSH, {1'b1, {(DATA_W-1){1'b0}}}, 0, 0, 1'b0);
		add_cmd(ACT_PUSH, '1, 0, 0, 1'b0);
		add_cmd(ACT_PUSH, '0, 3, 0, 1'b0);
		for (int i = 0; i < 4; i++)
			add_cmd(ACT_POP, ~32'h0, 5, 0, 1'b0);
		add_cmd(ACT_POP, '0, 0, 0, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			add_cmd(ACT_PUSH, 32'h5A5A_0000 + i, 5, 0, 1'b0);
		add_cmd(ACT_PUSH, 32'hDEAD_BEEF, 5, 0, 1'b0);
		add_cmd(ACT_POP, '0, 0, 0, 1'b0);

		// Random: bursts that fill one level, mix, or drain, so that full levels,
		// pointer wrap and underflow all come round often.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			if (made < RANDOM_ITEMS / 3)
				idle = 21;
			else if (made < 2 * RANDOM_ITEMS / 3)
				idle = 78;
			else
				idle = 0;
			mode      = $urandom_range(2);
			burst_len = $urandom_range(8, 40);
			hot       = $urandom_range(LEVELS - 1);
			push_pct  = (mode == 0) ? 85 : (mode == 1) ? 50 : 15;
			for (int i = 0; i < burst_len; i++) begin
				act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
				lv  = (mode == 0 && $urandom_range(3) != 0) ? hot
						: $urandom_range(LEVELS - 1);
				// Let the queue go quiet at the start of each pacing phase.
				add_cmd(act, pick_value(), lv, idle,
					made == RANDOM_ITEMS / 3 || made == 2 * RANDOM_ITEMS / 3);
				made++;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || start || reports_owed != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (pending_reports.size() != 0) begin
			$error("%0d predicted reports never arrived", pending_reports.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
